[rtl/core/string_token_unescape_utf8_defines.svh]
// Assertion macros for the checker file of the token unescaper.
`ifndef STRING_TOKEN_UNESCAPE_UTF8_DEFINES_SVH
`define STRING_TOKEN_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STUE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stue: same-cycle port check failed");

// Next-cycle implication, disabled during reset.
`define STUE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stue: next-cycle port check failed");

`endif

[rtl/core/stue_pkg.sv]
// Shared types, character codes and UTF-8 helpers for the token unescaper.
`default_nettype none
package stue_pkg;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_V  = 8'h76;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;

   localparam logic [15:0] HI_SURR_MIN = 16'hD800;
   localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
   localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
   localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE   = 21'h010000;

   typedef enum logic [1:0] {
      ST_DATA = 2'd0,
      ST_OK   = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_DOUBLE = 2'd1,
      QUOTE_SINGLE = 2'd2
   } quote_type;

   // One decode command: a raw byte, a code point to encode, or an end status.
   typedef struct packed {
      logic       raw;
      logic [20:0] cp;
      status_type st;
      logic       consumed;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   function automatic logic in_bare_set(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h2B ||
             c == 8'h5F || c == 8'h2E;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // {ok, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      return r;
   endfunction

   // Number of UTF-8 bytes minus one.
   function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
      logic [1:0] r;
      if (cp < 21'h80) r = 2'd0;
      else if (cp <= 21'h7FF) r = 2'd1;
      else if (cp <= 21'hFFFF) r = 2'd2;
      else r = 2'd3;
      return r;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
      logic [7:0] r;
      r = 8'h00;
      case (utf8_len_m1(cp))
         2'd0: r = cp[7:0];
         2'd1: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         2'd2: begin
            case (idx)
               2'd0:    r = {4'b1110, cp[15:12]};
               2'd1:    r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    r = {5'b11110, cp[20:18]};
               2'd1:    r = {2'b10, cp[17:12]};
               2'd2:    r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/stue_front.sv]
// Front end: accepts characters, runs the token parser, issues decode commands.
`default_nettype none
module stue_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tready,
   input  wire logic [7:0]          in_char,
   input  wire logic                start_token,
   input  wire logic                end_of_input,
   output stue_pkg::push_type       push
);
   import stue_pkg::*;

   typedef enum logic [8:0] {
      M_IDLE    = 9'b000000001,
      M_BARE    = 9'b000000010,
      M_QUOTED  = 9'b000000100,
      M_ESC     = 9'b000001000,
      M_HEX1    = 9'b000010000,
      M_SURR_BS = 9'b000100000,
      M_SURR_U  = 9'b001000000,
      M_HEX2    = 9'b010000000,
      M_CONT    = 9'b100000000
   } mode_type;

   mode_type    mode_ff, mode_in;
   quote_type   quote_ff, quote_in;
   logic [11:0] hex_ff, hex_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  hs_ff, hs_in;

   logic        accept;
   logic        emit;
   cmd_type     cmd;
   logic [4:0]  hv;
   logic [15:0] hcp;

   assign accept = req_tvalid && req_tready;
   assign hv     = hex_value(in_char);
   assign hcp    = {hex_ff, hv[3:0]};

   always_comb begin
      mode_in      = mode_ff;
      quote_in     = quote_ff;
      hex_in       = hex_ff;
      cnt_in       = cnt_ff;
      hs_in        = hs_ff;
      emit         = 1'b0;
      cmd.raw      = 1'b1;
      cmd.cp       = {13'd0, in_char};
      cmd.st       = ST_DATA;
      cmd.consumed = 1'b1;

      if (start_token) begin
         mode_in = M_IDLE;
         if (end_of_input) begin
            emit = 1'b1; cmd.st = ST_ERR; cmd.consumed = 1'b0;
         end else if (in_char == CH_DQUOTE) begin
            mode_in = M_QUOTED; quote_in = QUOTE_DOUBLE;
         end else if (in_char == CH_SQUOTE) begin
            mode_in = M_QUOTED; quote_in = QUOTE_SINGLE;
         end else if (in_bare_set(in_char)) begin
            mode_in = M_BARE; emit = 1'b1;
         end else begin
            emit = 1'b1; cmd.st = ST_ERR;
         end
      end else if (end_of_input) begin
         if (mode_ff != M_IDLE) begin
            mode_in = M_IDLE; emit = 1'b1; cmd.st = ST_ERR; cmd.consumed = 1'b0;
         end
      end else begin
         case (mode_ff)
            M_BARE: begin
               emit = 1'b1;
               if (!in_bare_set(in_char)) begin
                  mode_in = M_IDLE; cmd.st = ST_OK; cmd.consumed = 1'b0;
               end
            end
            M_QUOTED, M_CONT: begin
               if (mode_ff == M_CONT && is_space(in_char)) begin
                  mode_in = M_CONT;
               end else if ((in_char == CH_DQUOTE && quote_ff == QUOTE_DOUBLE) ||
                            (in_char == CH_SQUOTE && quote_ff == QUOTE_SINGLE)) begin
                  mode_in = M_IDLE; emit = 1'b1; cmd.st = ST_OK;
               end else if (in_char == CH_BSLASH) begin
                  mode_in = M_ESC;
               end else begin
                  mode_in = M_QUOTED; emit = 1'b1;
               end
            end
            M_ESC: begin
               mode_in = M_QUOTED;
               emit    = 1'b1;
               case (in_char)
                  CH_LF, CH_CR: begin
                     mode_in = M_CONT; emit = 1'b0;
                  end
                  CH_DQUOTE: begin
                     if (quote_ff != QUOTE_DOUBLE) begin
                        mode_in = M_IDLE; cmd.st = ST_ERR;
                     end
                  end
                  CH_SQUOTE: begin
                     if (quote_ff != QUOTE_SINGLE) begin
                        mode_in = M_IDLE; cmd.st = ST_ERR;
                     end
                  end
                  CH_BSLASH, CH_SLASH: cmd.cp = {13'd0, in_char};
                  CH_LOW_B: cmd.cp = {13'd0, CH_BS};
                  CH_LOW_F: cmd.cp = {13'd0, CH_FF};
                  CH_LOW_N: cmd.cp = {13'd0, CH_LF};
                  CH_LOW_R: cmd.cp = {13'd0, CH_CR};
                  CH_LOW_T: cmd.cp = {13'd0, CH_TAB};
                  CH_LOW_V: cmd.cp = {13'd0, CH_VT};
                  CH_LOW_U: begin
                     mode_in = M_HEX1; emit = 1'b0; hex_in = 12'd0; cnt_in = 2'd0;
                  end
                  default: begin
                     mode_in = M_IDLE; cmd.st = ST_ERR;
                  end
               endcase
            end
            M_HEX1, M_HEX2: begin
               if (!hv[4]) begin
                  mode_in = M_IDLE; emit = 1'b1; cmd.st = ST_ERR;
               end else if (cnt_ff != 2'd3) begin
                  hex_in = hcp[11:0];
                  cnt_in = cnt_ff + 2'd1;
               end else begin
                  hex_in = hcp[11:0];
                  cnt_in = 2'd0;
                  cmd.raw = 1'b0;
                  cmd.cp  = {5'd0, hcp};
                  if (mode_ff == M_HEX1) begin
                     if (hcp >= HI_SURR_MIN && hcp <= HI_SURR_MAX) begin
                        hs_in = hcp[9:0]; mode_in = M_SURR_BS;
                     end else if (hcp >= LO_SURR_MIN && hcp <= LO_SURR_MAX) begin
                        mode_in = M_IDLE; emit = 1'b1; cmd.st = ST_ERR;
                     end else begin
                        mode_in = M_QUOTED; emit = 1'b1;
                     end
                  end else begin
                     emit = 1'b1;
                     if (hcp >= LO_SURR_MIN && hcp <= LO_SURR_MAX) begin
                        mode_in = M_QUOTED;
                        cmd.cp  = SUPP_BASE + {1'b0, hs_ff, hcp[9:0]};
                     end else begin
                        mode_in = M_IDLE; cmd.st = ST_ERR;
                     end
                  end
               end
            end
            M_SURR_BS: begin
               if (in_char == CH_BSLASH) begin
                  mode_in = M_SURR_U;
               end else begin
                  mode_in = M_IDLE; emit = 1'b1; cmd.st = ST_ERR;
               end
            end
            M_SURR_U: begin
               if (in_char == CH_LOW_U) begin
                  mode_in = M_HEX2; hex_in = 12'd0; cnt_in = 2'd0;
               end else begin
                  mode_in = M_IDLE; emit = 1'b1; cmd.st = ST_ERR;
               end
            end
            default: mode_in = M_IDLE;
         endcase
      end

      if (cmd.st != ST_DATA) begin
         cmd.raw = 1'b1;
         cmd.cp  = 21'd0;
      end
   end

   assign push.push = accept && emit;
   assign push.cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         quote_ff <= QUOTE_NONE;
         hex_ff   <= 12'd0;
         cnt_ff   <= 2'd0;
         hs_ff    <= 10'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         hex_ff   <= hex_in;
         cnt_ff   <= cnt_in;
         hs_ff    <= hs_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/stue_queue.sv]
// Small command queue between the parser and the byte emitter.
`default_nettype none
module stue_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stue_pkg::push_type push,
   input  wire logic               pop,
   output stue_pkg::head_type      head,
   output logic                    full
);
   import stue_pkg::*;

   cmd_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ff, wr_in;
   logic [Q_PTR_W-1:0]   rd_ff, rd_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 do_pop;

   assign full       = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.cmd   = mem_ff[rd_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_in  = push.push ? wr_ff + Q_PTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + Q_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push.push && !do_pop) cnt_in = cnt_ff + Q_CNT_W'(1);
      else if (!push.push && do_pop) cnt_in = cnt_ff - Q_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push.push) mem_ff[wr_ff] <= push.cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/stue_back.sv]
// Back end: expands queued commands into output words, one byte per cycle while rsp_tready is high.
`default_nettype none
module stue_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stue_pkg::head_type head,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic [2:0]              rsp_tuser,
   output logic                    rsp_tlast
);
   import stue_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   logic [7:0] byte_ff;
   logic [2:0] user_ff;
   logic       last_ff;

   logic       load;
   logic       simple;
   logic [1:0] len_m1;
   logic       is_last;
   logic [7:0] byte_val;

   assign simple   = head.cmd.raw || (head.cmd.st != ST_DATA);
   assign len_m1   = simple ? 2'd0 : utf8_len_m1(head.cmd.cp);
   assign is_last  = (idx_ff == len_m1);
   assign byte_val = head.cmd.raw ? head.cmd.cp[7:0] : utf8_byte(head.cmd.cp, idx_ff);
   assign load     = head.valid && (!vld_ff || rsp_tready);
   assign pop      = load && is_last;

   always_comb begin
      idx_in = idx_ff;
      vld_in = vld_ff;
      if (rsp_tready) vld_in = 1'b0;
      if (load) begin
         vld_in = 1'b1;
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_val;
         user_ff <= {head.cmd.consumed, head.cmd.st};
         last_ff <= is_last;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

[rtl/core/string_token_unescape_utf8.sv]
// Usage: string token unescaper with UTF-8 output.
// req channel carries one token character per word; tuser bit 0 marks the
// first character of a token, tuser bit 1 marks end of input (tdata ignored).
// rsp channel carries decoded bytes; tuser[1:0] is the status (data, token
// finished, token error), tuser[2] is clear when the character that caused
// the word was not consumed, tlast flags the last word caused by one input.
// A front parser takes one character per cycle while the queue is not full
// and pushes at most one command into a four-entry queue; the back end
// expands each command into one to four words, one word per cycle while
// rsp_tready is high, through a registered output stage that the words
// reach after the queue. Throughput: one character per cycle while each
// makes at most one word and the output is not stalled; \u escapes yielding
// two to four UTF-8 bytes hold the output until those bytes are out, and
// req_tready drops only when the queue is full.
// Reset clears the parser, the queue and the output stage; an open token is
// dropped. A stall on rsp_tready holds the output word and backs up the
// queue, then req_tready.
`default_nettype none
module string_token_unescape_utf8 (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // in_char
   input  wire logic [1:0] req_tuser,  // start_token, end_of_input
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,  // out_byte
   output logic [2:0]      rsp_tuser,  // status[1:0], char_consumed
   output logic            rsp_tlast   // last_of_run
);
   import stue_pkg::*;

   push_type push;
   head_type head;
   logic     full;
   logic     pop;

   assign req_tready = !full;

   stue_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .in_char      (req_tdata),
      .start_token  (req_tuser[0]),
      .end_of_input (req_tuser[1]),
      .push         (push)
   );

   stue_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   stue_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

[rtl/core/stue_checker.sv]
// Port-level checker for the token unescaper and its bind.
`default_nettype none
`include "string_token_unescape_utf8_defines.svh"
module stue_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [2:0] rsp_tuser,
   input wire logic       rsp_tlast
);
   import stue_pkg::*;

   // stalled word holds
   `STUE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   // status words carry a zero byte and close the run
   `STUE_ASSERT_IMP(a_status_word, clock, reset, rsp_tvalid && rsp_tuser[1:0] != ST_DATA, rsp_tdata == 8'h00 && rsp_tlast)
   // an unconsumed character only ever ends a token
   `STUE_ASSERT_IMP(a_unconsumed, clock, reset, rsp_tvalid && !rsp_tuser[2], rsp_tuser[1:0] == ST_OK || rsp_tuser[1:0] == ST_ERR)
   // status code is one of the defined ones
   `STUE_ASSERT_IMP(a_status_code, clock, reset, rsp_tvalid, rsp_tuser[1:0] == ST_DATA || rsp_tuser[1:0] == ST_OK || rsp_tuser[1:0] == ST_ERR)

endmodule

bind string_token_unescape_utf8 stue_checker u_stue_checker (.*);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the string token unescaper: directed rows, then random tokens.
module testbench;
   import stue_pkg::*;

   typedef enum logic [3:0] {
      PM_IDLE, PM_BARE, PM_QUOTED, PM_ESC, PM_HEX1, PM_SURR_BS, PM_SURR_U, PM_HEX2, PM_CONT
   } parse_mode_e;

   typedef enum logic [1:0] {QK_NONE, QK_DOUBLE, QK_SINGLE} quote_kind_e;

   // How a directed row is checked: by the decoder model, as giving no word, or against a typed-in word.
   typedef enum logic [1:0] {ROW_DECODED, ROW_SILENT, ROW_SINGLE} row_kind_e;

   typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SLOW} rx_style_e;

   typedef struct packed {
      logic [7:0] data;
      status_type st;
      logic       consumed;
      logic       last;
   } out_word_t;

   typedef struct {
      logic [7:0] ch;
      logic       start;
      logic       eoi;
      row_kind_e  kind;
      logic [7:0] data;
      status_type st;
      logic       consumed;
   } dir_row_t;

   localparam int RANDOM_ITEMS = 330;
   localparam int DRAIN_CYCLES = 20;
   localparam int NUM_ROWS     = 26;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic [1:0] req_tuser  = 2'b00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   string_token_unescape_utf8 u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // decoder model state
   parse_mode_e pmode;
   quote_kind_e qkind;
   logic [15:0] hex_acc;
   logic [1:0]  hex_cnt;
   logic [15:0] hi_surr;

   out_word_t step_words[$];
   out_word_t pending_words[$];

   int burst_left  = 0;
   int live_items  = 0;
   int mismatches  = 0;
   int rx_left     = 0;
   rx_style_e rx_style = RX_STREAM;

   dir_row_t   dir_rows[NUM_ROWS];
   string      bare_pool  = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-+_.";
   string      hex_pool   = "0123456789abcdefABCDEF";
   logic [7:0] blank_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   logic [7:0] esc_set[8]   = '{CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F,
                                CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_V};

   function automatic void add_word(input logic [7:0] b, input status_type st,
                                    input logic cons);
      out_word_t w;
      w.data     = b;
      w.st       = st;
      w.consumed = cons;
      w.last     = 1'b0;
      step_words = {step_words, w};
   endfunction

   function automatic void drop_token();
      pmode   = PM_IDLE;
      qkind   = QK_NONE;
      hex_acc = 16'h0000;
      hex_cnt = 2'd0;
      hi_surr = 16'h0000;
   endfunction

   function automatic void end_token(input status_type st, input logic cons);
      drop_token();
      add_word(8'h00, st, cons);
   endfunction

   function automatic logic bare_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             c == "-" || c == "+" || c == "_" || c == ".";
   endfunction

   function automatic logic blank_char(input logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "A" && c <= "F") return int'(c - 8'h37);
      if (c >= "a" && c <= "f") return int'(c - 8'h57);
      return -1;
   endfunction

   function automatic void encode_utf8(input logic [31:0] cp);
      if (cp < 32'h80) begin
         add_word(cp[7:0], ST_DATA, 1'b1);
      end else if (cp <= 32'h7FF) begin
         add_word(8'hC0 | 8'(cp >> 6), ST_DATA, 1'b1);
         add_word(8'h80 | 8'(cp & 32'h3F), ST_DATA, 1'b1);
      end else if (cp <= 32'hFFFF) begin
         add_word(8'hE0 | 8'(cp >> 12), ST_DATA, 1'b1);
         add_word(8'h80 | 8'((cp >> 6) & 32'h3F), ST_DATA, 1'b1);
         add_word(8'h80 | 8'(cp & 32'h3F), ST_DATA, 1'b1);
      end else begin
         add_word(8'hF0 | 8'((cp >> 18) & 32'h7), ST_DATA, 1'b1);
         add_word(8'h80 | 8'((cp >> 12) & 32'h3F), ST_DATA, 1'b1);
         add_word(8'h80 | 8'((cp >> 6) & 32'h3F), ST_DATA, 1'b1);
         add_word(8'h80 | 8'(cp & 32'h3F), ST_DATA, 1'b1);
      end
   endfunction

   function automatic void quoted_step(input logic [7:0] c);
      pmode = PM_QUOTED;
      if (c == CH_DQUOTE && qkind == QK_DOUBLE) end_token(ST_OK, 1'b1);
      else if (c == CH_SQUOTE && qkind == QK_SINGLE) end_token(ST_OK, 1'b1);
      else if (c == CH_BSLASH) pmode = PM_ESC;
      else add_word(c, ST_DATA, 1'b1);
   endfunction

   function automatic void escape_step(input logic [7:0] c);
      logic [7:0] b;
      logic       ok;
      logic       emit;
      pmode = PM_QUOTED;
      b     = c;
      ok    = 1'b1;
      emit  = 1'b1;
      case (c)
         CH_LF, CH_CR: begin
            pmode = PM_CONT;
            emit  = 1'b0;
         end
         CH_DQUOTE: ok = (qkind == QK_DOUBLE);
         CH_SQUOTE: ok = (qkind == QK_SINGLE);
         CH_BSLASH, CH_SLASH: ;
         CH_LOW_B: b = CH_BS;
         CH_LOW_F: b = CH_FF;
         CH_LOW_N: b = CH_LF;
         CH_LOW_R: b = CH_CR;
         CH_LOW_T: b = CH_TAB;
         CH_LOW_V: b = CH_VT;
         CH_LOW_U: begin
            pmode   = PM_HEX1;
            hex_acc = 16'h0000;
            hex_cnt = 2'd0;
            emit    = 1'b0;
         end
         default: ok = 1'b0;
      endcase
      if (!ok) end_token(ST_ERR, 1'b1);
      else if (emit) add_word(b, ST_DATA, 1'b1);
   endfunction

   function automatic void hex_step(input logic [7:0] c);
      int          d;
      logic [31:0] cp;
      d = hex_digit_value(c);
      if (d < 0) begin
         end_token(ST_ERR, 1'b1);
         return;
      end
      hex_acc = {hex_acc[11:0], 4'(d)};
      if (hex_cnt < 2'd3) begin
         hex_cnt = hex_cnt + 2'd1;
         return;
      end
      hex_cnt = 2'd0;
      cp = {16'h0000, hex_acc};
      if (pmode == PM_HEX1) begin
         if (hex_acc >= HI_SURR_MIN && hex_acc <= HI_SURR_MAX) begin
            hi_surr = hex_acc;
            pmode   = PM_SURR_BS;
            return;
         end
         if (hex_acc >= LO_SURR_MIN && hex_acc <= LO_SURR_MAX) begin
            end_token(ST_ERR, 1'b1);
            return;
         end
      end else begin
         if (!(hex_acc >= LO_SURR_MIN && hex_acc <= LO_SURR_MAX)) begin
            end_token(ST_ERR, 1'b1);
            return;
         end
         // join the pair: (hi << 10) + lo - (0xD800 << 10) - 0xDC00 + 0x10000
         cp = ({16'h0000, hi_surr} << 10) + cp - 32'h035FDC00;
      end
      pmode   = PM_QUOTED;
      hex_acc = 16'h0000;
      hi_surr = 16'h0000;
      encode_utf8(cp);
   endfunction

   // Words caused by one input character land in step_words, last one flagged.
   function automatic void decode_step(input logic [7:0] c, input logic start, input logic eoi);
      step_words.delete();
      if (start) begin
         drop_token();
         if (eoi) end_token(ST_ERR, 1'b0);
         else if (c == CH_DQUOTE) begin
            pmode = PM_QUOTED;
            qkind = QK_DOUBLE;
         end else if (c == CH_SQUOTE) begin
            pmode = PM_QUOTED;
            qkind = QK_SINGLE;
         end else if (bare_char(c)) begin
            pmode = PM_BARE;
            add_word(c, ST_DATA, 1'b1);
         end else end_token(ST_ERR, 1'b1);
      end else if (eoi) begin
         if (pmode != PM_IDLE) end_token(ST_ERR, 1'b0);
      end else begin
         case (pmode)
            PM_BARE:
               if (bare_char(c)) add_word(c, ST_DATA, 1'b1);
               else end_token(ST_OK, 1'b0);
            PM_QUOTED: quoted_step(c);
            PM_ESC: escape_step(c);
            PM_HEX1, PM_HEX2: hex_step(c);
            PM_SURR_BS:
               if (c == CH_BSLASH) pmode = PM_SURR_U;
               else end_token(ST_ERR, 1'b1);
            PM_SURR_U:
               if (c == CH_LOW_U) begin
                  pmode   = PM_HEX2;
                  hex_acc = 16'h0000;
                  hex_cnt = 2'd0;
               end else end_token(ST_ERR, 1'b1);
            PM_CONT:
               if (!blank_char(c)) quoted_step(c);
            default: drop_token();
         endcase
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
   endfunction

   // Drives one character word; returns just after the edge that accepted it.
   task automatic send_char(input logic [7:0] c, input logic start, input logic eoi,
                            input row_kind_e kind = ROW_DECODED,
                            input out_word_t typed = '0);
      int gap;
      live_items++;
      decode_step(c, start, eoi);
      if (kind == ROW_DECODED) foreach (step_words[i]) pending_words = {pending_words, step_words[i]};
      else if (kind == ROW_SINGLE) pending_words = {pending_words, typed};
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= {eoi, start};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_hex16(input logic [15:0] v);
      logic [3:0] nib;
      logic [7:0] c;
      for (int i = 3; i >= 0; i--) begin
         nib = v[4*i +: 4];
         if (nib < 4'd10) c = 8'h30 + {4'h0, nib};
         else if ($urandom_range(0, 1) == 1) c = 8'h41 + {4'h0, nib - 4'd10};
         else c = 8'h61 + {4'h0, nib - 4'd10};
         send_char(c, 1'b0, 1'b0);
      end
   endtask

   // Stop sending and let every expected word come out.
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // receiver: switches at random between streaming, coin-flip and slow stall styles
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_style = rx_style_e'($urandom_range(0, 2));
         rx_left  = $urandom_range(8, 60);
      end
      rx_left--;
      case (rx_style)
         RX_STREAM: rsp_tready <= 1'b1;
         RX_COIN: rsp_tready <= ($urandom_range(0, 1) == 1);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      out_word_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected word: data %02h status %0d consumed %b last %b",
                        rsp_tdata, rsp_tuser[1:0], rsp_tuser[2], rsp_tlast);
            mismatches++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata !== want.data || rsp_tuser[1:0] !== want.st ||
                rsp_tuser[2] !== want.consumed || rsp_tlast !== want.last) begin
               if (mismatches < 10)
                  $display({"word mismatch: expected data %02h status %0d consumed %b last %b,",
                            " got data %02h status %0d consumed %b last %b"},
                           want.data, want.st, want.consumed, want.last,
                           rsp_tdata, rsp_tuser[1:0], rsp_tuser[2], rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      out_word_t   typed;
      logic [7:0]  c;
      logic [7:0]  close_q;
      logic [15:0] cp;
      int          sel;

      dir_rows = '{
         '{"x",       1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0}, // no token open
         '{8'h00,     1'b0, 1'b1, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{8'h00,     1'b1, 1'b0, ROW_SINGLE, 8'h00,  ST_ERR,  1'b1}, // bad first char
         '{"a",       1'b1, 1'b0, ROW_SINGLE, "a",    ST_DATA, 1'b1},
         '{8'hFF,     1'b0, 1'b0, ROW_SINGLE, 8'h00,  ST_OK,   1'b0}, // bare terminator
         '{CH_DQUOTE, 1'b1, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{8'h80,     1'b0, 1'b0, ROW_SINGLE, 8'h80,  ST_DATA, 1'b1},
         '{CH_BSLASH, 1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{CH_LOW_N,  1'b0, 1'b0, ROW_SINGLE, CH_LF,  ST_DATA, 1'b1},
         '{CH_BSLASH, 1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{CH_CR,     1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0}, // line continuation
         '{" ",       1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{CH_BSLASH, 1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{CH_LOW_U,  1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{"0",       1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{"0",       1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{"e",       1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{"9",       1'b0, 1'b0, ROW_DECODED, 8'h00, ST_DATA, 1'b0}, // two-byte code point
         '{8'h00,     1'b0, 1'b1, ROW_SINGLE, 8'h00,  ST_ERR,  1'b0}, // runs out
         '{CH_SQUOTE, 1'b1, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{CH_BSLASH, 1'b0, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{CH_DQUOTE, 1'b0, 1'b0, ROW_SINGLE, 8'h00,  ST_ERR,  1'b1}, // opposite quote
         '{"-",       1'b1, 1'b0, ROW_SINGLE, "-",    ST_DATA, 1'b1},
         '{8'hFF,     1'b1, 1'b1, ROW_SINGLE, 8'h00,  ST_ERR,  1'b0}, // drops open token
         '{CH_SQUOTE, 1'b1, 1'b0, ROW_SILENT, 8'h00,  ST_DATA, 1'b0},
         '{CH_SQUOTE, 1'b0, 1'b0, ROW_SINGLE, 8'h00,  ST_OK,   1'b1}
      };

      drop_token();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         typed.data     = dir_rows[i].data;
         typed.st       = dir_rows[i].st;
         typed.consumed = dir_rows[i].consumed;
         typed.last     = 1'b1;
         send_char(dir_rows[i].ch, dir_rows[i].start, dir_rows[i].eoi, dir_rows[i].kind, typed);
      end
      drain_pipeline();

      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            // quoted token: random body, then closed properly or ended by a fault or left open
            close_q = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
            send_char(close_q, 1'b1, 1'b0);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 5))
                  0, 1: begin
                     do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH || c == close_q);
                     send_char(c, 1'b0, 1'b0);
                  end
                  2: begin
                     send_char(CH_BSLASH, 1'b0, 1'b0);
                     sel = $urandom_range(0, 8);
                     send_char((sel == 8) ? close_q : esc_set[sel], 1'b0, 1'b0);
                  end
                  3: begin
                     case ($urandom_range(0, 2))
                        0: cp = 16'($urandom_range(0, 16'h007F));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        default:
                           do cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                           while (cp >= HI_SURR_MIN && cp <= LO_SURR_MAX);
                     endcase
                     send_char(CH_BSLASH, 1'b0, 1'b0);
                     send_char(CH_LOW_U, 1'b0, 1'b0);
                     send_hex16(cp);
                  end
                  4: begin
                     send_char(CH_BSLASH, 1'b0, 1'b0);
                     send_char(CH_LOW_U, 1'b0, 1'b0);
                     send_hex16(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
                     send_char(CH_BSLASH, 1'b0, 1'b0);
                     send_char(CH_LOW_U, 1'b0, 1'b0);
                     send_hex16(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
                  end
                  default: begin
                     send_char(CH_BSLASH, 1'b0, 1'b0);
                     send_char(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF, 1'b0, 1'b0);
                     repeat ($urandom_range(0, 3))
                        send_char(blank_set[$urandom_range(0, 5)], 1'b0, 1'b0);
                  end
               endcase
            end
            case ($urandom_range(0, 9))
               0: send_char(8'h00, 1'b0, 1'b1);
               1: begin
                  // escape with any byte, mostly unknown ones
                  send_char(CH_BSLASH, 1'b0, 1'b0);
                  send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
               end
               2: begin
                  send_char(CH_BSLASH, 1'b0, 1'b0);
                  send_char(CH_LOW_U, 1'b0, 1'b0);
                  repeat ($urandom_range(0, 3))
                     send_char(hex_pool[$urandom_range(0, 21)], 1'b0, 1'b0);
                  send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
               end
               3: begin
                  send_char(CH_BSLASH, 1'b0, 1'b0);
                  send_char(CH_LOW_U, 1'b0, 1'b0);
                  send_hex16(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
               end
               4: begin
                  // high surrogate followed by something that may not be a low one
                  send_char(CH_BSLASH, 1'b0, 1'b0);
                  send_char(CH_LOW_U, 1'b0, 1'b0);
                  send_hex16(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
                  case ($urandom_range(0, 2))
                     0: send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                     1: begin
                        send_char(CH_BSLASH, 1'b0, 1'b0);
                        send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                     end
                     default: begin
                        send_char(CH_BSLASH, 1'b0, 1'b0);
                        send_char(CH_LOW_U, 1'b0, 1'b0);
                        send_hex16(16'($urandom_range(0, 16'hFFFF)));
                     end
                  endcase
               end
               5: ; // left open: the next start drops it
               default: send_char(close_q, 1'b0, 1'b0);
            endcase
         end else if (sel < 85) begin
            send_char(bare_pool[$urandom_range(0, bare_pool.len() - 1)], 1'b1, 1'b0);
            repeat ($urandom_range(0, 6))
               send_char(bare_pool[$urandom_range(0, bare_pool.len() - 1)], 1'b0, 1'b0);
            case ($urandom_range(0, 5))
               0: send_char(8'h00, 1'b0, 1'b1);
               1: ;
               default: begin
                  do c = 8'($urandom_range(0, 255)); while (bare_char(c));
                  send_char(c, 1'b0, 1'b0);
               end
            endcase
         end else begin
            repeat ($urandom_range(1, 3))
               send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                         ($urandom_range(0, 7) == 0));
         end
         if ($urandom_range(0, 29) == 0) drain_pipeline();
      end

      drain_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/stue_pkg.sv
rtl/core/stue_front.sv
rtl/core/stue_queue.sv
rtl/core/stue_back.sv
rtl/core/string_token_unescape_utf8.sv
rtl/core/stue_checker.sv
tb/testbench.sv
